/* sv/bra_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants of the bearer rate average block.
// No dependencies; every other file imports this package.
package bra_pkg;

  localparam int AVG_W     = 40;   // average rate, unsigned fixed point
  localparam int TOTAL_W   = 32;   // byte accumulator
  localparam int BYTE_W    = 16;   // byte count of one add item
  localparam int TIME_W    = 32;   // tick counter
  localparam int IN_DATA_W  = 48;  // byte_count, now_ticks
  localparam int OUT_DATA_W = 72;  // average_rate, bytes_so_far

  localparam int TICKS_PER_SECOND_DEF = 1000;
  localparam int FRACTION_BITS_DEF    = 8;

  localparam logic [TOTAL_W-1:0] INIT_RATE_RST = 32'd100000;
  localparam logic [AVG_W-1:0]   AVG_MAX       = '1;

  // The blend divides 4*avg + rate (43 bits) by five.
  localparam int                BLEND_W   = AVG_W + 3;
  localparam logic [TIME_W-1:0] BLEND_DEN = 32'd5;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_RATE,
    ST_BLEND_GO,
    ST_DIV_BLEND,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic done;  // quotient valid this cycle
    logic sat;   // quotient overflowed the average width
  } div_stat_t;

  // Starting average: the register value shifted into fixed point, saturated.
  function automatic logic [AVG_W-1:0] load_initial(input logic [TOTAL_W-1:0] value,
                                                    input int fbits);
    logic [63:0] v;
    v = 64'(value) << fbits;
    return (v > 64'(AVG_MAX)) ? AVG_MAX : v[AVG_W-1:0];
  endfunction

endpackage

/* sv/bearer_rate_average.sv */
`timescale 1ns / 1ps
// Per-bearer moving-average throughput: control sequencer and state.
// Depends on bra_pkg, bra_mul and bra_div.
//
// Usage. Items arrive on the s_axis channel: tuser[0] is the opcode (add or
// update), tdata carries the byte count and the current tick time. An add item
// adds its byte count to a saturating 32-bit accumulator. An update item turns
// the bytes since the last update into a rate in bits per second, blends it as
// 0.8*avg + 0.2*rate, floors the result at 1.0, clears the accumulator and
// records the time. Every item yields exactly one result on m_axis: the
// average and the byte total as they stand after the item.
// Sequencing. One item is worked on at a time. An add item's result is
// loaded in ST_FINISH, which follows acceptance, once the output register is
// free. An update item runs the serial shift-add multiplier (KW bits of
// 8*TICKS_PER_SECOND), then the shared one-bit-per-cycle divider (RW rate
// steps, then 43 steps of the blend by five), then ST_FINISH. When the byte
// total is zero or no time has passed the rate is known at once and only the
// blend runs.
// Stalls. The result sits in an output register; a new item is accepted
// while it waits, but that item's result waits until the register is taken.
// Reset clears the accumulator and the time and loads the average from the
// reset value of the initial rate. A write on the cfg channel loads the
// average from the written initial rate at once.
module bearer_rate_average import bra_pkg::*; #(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
  parameter int FRACTION_BITS    = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration: initial_rate, bits per second.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [TOTAL_W-1:0]    cfg_data_i,
  // Input items.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] byte_count, [47:16] now_ticks
  input  logic [0:0]            s_axis_tuser,   // [0] opcode
  // Result items.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [39:0] average_rate, [71:40] bytes_so_far
);

  localparam int K   = 8 * TICKS_PER_SECOND;
  localparam int KW  = $clog2(K + 1);
  localparam int PW  = TOTAL_W + KW;
  localparam int RW  = PW + FRACTION_BITS;          // rate numerator width
  localparam int NW  = (RW > BLEND_W) ? RW : BLEND_W;
  localparam int SW  = $clog2(NW + 1);
  localparam logic [AVG_W-1:0] AVG_ONE = AVG_W'(1) << FRACTION_BITS;
  localparam logic [AVG_W-1:0] AVG_RST = load_initial(INIT_RATE_RST, FRACTION_BITS);

  state_e state_q, state_d;

  logic [AVG_W-1:0]   avg_q;
  logic [TOTAL_W-1:0] total_q;
  logic [TIME_W-1:0]  last_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  dt_q;
  logic [AVG_W-1:0]   rate_q;
  logic               m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic [BYTE_W-1:0]  in_bytes;
  logic [TIME_W-1:0]  in_now;
  op_e                in_op;
  logic               in_acc;
  logic               cfg_acc;
  logic [TIME_W-1:0]  in_dt;
  logic [TOTAL_W:0]   add_sum;

  logic               mul_start;
  logic               mul_done;
  logic [PW-1:0]      mul_prod;
  logic               div_start;
  logic               div_blend;
  logic [NW-1:0]      div_num;
  logic [TIME_W-1:0]  div_den;
  logic [SW-1:0]      div_steps;
  div_stat_t          div_stat;
  logic [AVG_W-1:0]   div_quo;
  logic [BLEND_W-1:0] blend_sum;
  logic               out_load;

  assign in_bytes = s_axis_tdata[BYTE_W-1:0];
  assign in_now   = s_axis_tdata[BYTE_W +: TIME_W];
  assign in_op    = op_e'(s_axis_tuser[0]);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign in_dt    = in_now - last_q;
  assign add_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(in_bytes);
  assign blend_sum = {1'b0, avg_q, 2'b00} + BLEND_W'(rate_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_ADD) begin
            state_d = ST_FINISH;
          end else if (total_q == '0 || in_dt == '0) begin
            state_d = ST_BLEND_GO;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_d = ST_DIV_RATE;
        end
      end
      ST_DIV_RATE: begin
        if (div_stat.done) begin
          state_d = ST_BLEND_GO;
        end
      end
      ST_BLEND_GO: begin
        state_d = ST_DIV_BLEND;
      end
      ST_DIV_BLEND: begin
        if (div_stat.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    div_blend     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        mul_start = in_acc && (in_op == OP_UPDATE) && (total_q != '0) && (in_dt != '0);
      end
      ST_MUL: begin
        div_start = mul_done;
      end
      ST_BLEND_GO: begin
        div_start = 1'b1;
        div_blend = 1'b1;
      end
      ST_FINISH: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  // Divider operands: both numerators are left aligned in the shift register.
  assign div_num   = div_blend ? (NW'(blend_sum) << (NW - BLEND_W))
                               : (NW'(mul_prod) << (FRACTION_BITS + NW - RW));
  assign div_den   = div_blend ? BLEND_DEN : dt_q;
  assign div_steps = div_blend ? SW'(BLEND_W) : SW'(RW);

  bra_mul #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_mul (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (mul_start),
    .multiplicand_i(total_q),
    .done_o        (mul_done),
    .product_o     (mul_prod)
  );

  bra_div #(
    .NW(NW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .steps_i(div_steps),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  // Control state and the bearer's running state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      avg_q     <= AVG_RST;
      total_q   <= '0;
      last_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        avg_q <= load_initial(cfg_data_i, FRACTION_BITS);
      end
      if (state_q == ST_IDLE && in_acc && in_op == OP_ADD) begin
        total_q <= add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];
      end
      if (state_q == ST_DIV_BLEND && div_stat.done) begin
        // The blend never exceeds the maximum; only the floor of 1.0 applies.
        avg_q   <= (div_quo < AVG_ONE) ? AVG_ONE : div_quo;
        total_q <= '0;
        last_q  <= now_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      now_q  <= in_now;
      dt_q   <= in_dt;
      // Rate for the cases that skip the division: no bytes gives zero,
      // bytes in no time give the maximum.
      rate_q <= (total_q == '0) ? '0 : AVG_MAX;
    end
    if (state_q == ST_DIV_RATE && div_stat.done) begin
      rate_q <= div_stat.sat ? AVG_MAX : div_quo;
    end
    if (out_load) begin
      m_data_q <= {total_q, avg_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* sv/bra_mul.sv */
`timescale 1ns / 1ps
// Shift-and-add multiplier of the byte total by 8*TICKS_PER_SECOND,
// one constant bit per cycle. Depends on bra_pkg.
module bra_mul import bra_pkg::*; #(
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
  localparam int K  = 8 * TICKS_PER_SECOND,
  localparam int KW = $clog2(K + 1),
  localparam int PW = TOTAL_W + KW,
  localparam int CW = $clog2(KW + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TOTAL_W-1:0] multiplicand_i,
  output logic               done_o,
  output logic [PW-1:0]      product_o
);

  localparam logic [KW-1:0] KCONST = KW'(K);

  logic [PW-1:0] acc_q, acc_d;
  logic [PW-1:0] addend_q, addend_d;
  logic [KW-1:0] kbits_q, kbits_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    addend_d = addend_q;
    kbits_d  = kbits_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      addend_d = PW'(multiplicand_i);
      kbits_d  = KCONST;
      cnt_d    = CW'(KW);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (kbits_q[0]) begin
        acc_d = acc_q + addend_q;
      end
      addend_d = addend_q << 1;
      kbits_d  = kbits_q >> 1;
      cnt_d    = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    addend_q <= addend_d;
    kbits_q  <= kbits_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

/* sv/bra_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, numerator fed MSB first.
// Shared by the rate division and the blend by five. Depends on bra_pkg.
module bra_div import bra_pkg::*; #(
  parameter int NW = 64,
  localparam int SW = $clog2(NW + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NW-1:0]     num_i,    // left aligned
  input  logic [TIME_W-1:0] den_i,
  input  logic [SW-1:0]     steps_i,
  output div_stat_t         stat_o,
  output logic [AVG_W-1:0]  quo_o
);

  logic [NW-1:0]     num_q, num_d;
  logic [TIME_W-1:0] den_q, den_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [AVG_W-1:0]  quo_q, quo_d;
  logic              sat_q, sat_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      sat_d  = 1'b0;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_d = {quo_q[AVG_W-2:0], ge};
      sat_d = sat_q | quo_q[AVG_W-1];
      cnt_d = cnt_q - SW'(1);
      if (cnt_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    sat_q <= sat_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;
  assign quo_o       = quo_q;

endmodule
